// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the triangle split modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Types and constants for the triangle to trapezoid split pipeline.
// ----------------------------------------------------------------------------
package tts_pkg;

  // signed Q12.4 screen coordinate
  typedef logic signed [15:0] coord_t;
  // difference of two coordinates
  typedef logic signed [16:0] diff_t;
  // product of two differences
  typedef logic signed [33:0] prod_t;
  // vertex index, 0=a 1=b 2=c
  typedef logic [1:0] vidx_t;

  localparam vidx_t VIDX_A = 2'd0;
  localparam vidx_t VIDX_B = 2'd1;
  localparam vidx_t VIDX_C = 2'd2;

  // triangle class found in setup
  typedef enum logic [1:0] {
    KIND_REJECT,
    KIND_FLAT_TOP,
    KIND_FLAT_BOT,
    KIND_SPLIT
  } kind_e;

  // input item
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
  } tts_in_t;

  // result item
  typedef struct packed {
    logic   trap_valid;
    coord_t top_y;
    coord_t bottom_y;
    vidx_t  left_start;
    vidx_t  left_end;
    vidx_t  right_start;
    vidx_t  right_end;
    logic   last;
  } tts_out_t;

  // after the y sort
  typedef struct packed {
    vidx_t   i1;
    vidx_t   i2;
    vidx_t   i3;
    tts_in_t verts;
  } sort_t;

  // after classification and edge differences
  typedef struct packed {
    kind_e  kind;
    vidx_t  i1;
    vidx_t  i2;
    vidx_t  i3;
    coord_t y1;
    coord_t y2;
    coord_t y3;
    diff_t  dx21;
    diff_t  dy31;
    diff_t  dx31;
    diff_t  dy21;
  } prep_t;

  // after the cross products
  typedef struct packed {
    kind_e  kind;
    vidx_t  i1;
    vidx_t  i2;
    vidx_t  i3;
    coord_t y1;
    coord_t y2;
    coord_t y3;
    prod_t  lhs;
    prod_t  rhs;
  } side_t;

endpackage

// ===== hdl/tts_sort.sv =====
// ----------------------------------------------------------------------------
// tts_sort
// Stage 1: orders the three vertices by y with strict compare-swaps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tts_sort import tts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  tts_in_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  output sort_t   data_o,
  input  logic    ready_i
);

  coord_t ys [3];
  logic   gt [3][3];
  vidx_t  i1_c, i2_c, i3_c, t_c;
  logic   valid_q;
  sort_t  data_q;

  // all pairwise compares side by side
  always_comb begin
    ys[0] = data_i.ay;
    ys[1] = data_i.by_coord;
    ys[2] = data_i.cy;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        gt[a][b] = (ys[a] > ys[b]);
      end
    end
  end

  // swaps on (0,1), (0,2), (1,2) steered by the compare bits
  always_comb begin
    i1_c = VIDX_A;
    i2_c = VIDX_B;
    i3_c = VIDX_C;
    t_c  = VIDX_A;
    if (gt[i1_c][i2_c]) begin
      t_c = i1_c; i1_c = i2_c; i2_c = t_c;
    end
    if (gt[i1_c][i3_c]) begin
      t_c = i1_c; i1_c = i3_c; i3_c = t_c;
    end
    if (gt[i2_c][i3_c]) begin
      t_c = i2_c; i2_c = i3_c; i3_c = t_c;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q.i1    <= i1_c;
      data_q.i2    <= i2_c;
      data_q.i3    <= i3_c;
      data_q.verts <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // sorted indices are a permutation of a, b, c
  `ASSERT_RST(a_sort_perm, clk_i, rst_ni,
    valid_q |-> ((data_q.i1 != data_q.i2) && (data_q.i1 != data_q.i3) &&
                 (data_q.i2 != data_q.i3) && (data_q.i1 != 2'd3) &&
                 (data_q.i2 != 2'd3) && (data_q.i3 != 2'd3)),
    "sorted vertex indices are not a permutation")

endmodule

// ===== hdl/tts_prep.sv =====
// ----------------------------------------------------------------------------
// tts_prep
// Stage 2: classifies the sorted triangle and forms the edge differences.
// ----------------------------------------------------------------------------
module tts_prep import tts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  sort_t data_i,
  output logic  ready_o,
  output logic  valid_o,
  output prep_t data_o,
  input  logic  ready_i
);

  coord_t x1, x2, x3, y1, y2, y3;
  prep_t  prep_d;
  logic   valid_q;
  prep_t  data_q;

  function automatic coord_t get_x(tts_in_t v, vidx_t i);
    coord_t r;
    case (i)
      VIDX_A:  r = v.ax;
      VIDX_B:  r = v.bx;
      default: r = v.cx;
    endcase
    return r;
  endfunction

  function automatic coord_t get_y(tts_in_t v, vidx_t i);
    coord_t r;
    case (i)
      VIDX_A:  r = v.ay;
      VIDX_B:  r = v.by_coord;
      default: r = v.cy;
    endcase
    return r;
  endfunction

  // sorted coordinates
  always_comb begin
    x1 = get_x(data_i.verts, data_i.i1);
    x2 = get_x(data_i.verts, data_i.i2);
    x3 = get_x(data_i.verts, data_i.i3);
    y1 = get_y(data_i.verts, data_i.i1);
    y2 = get_y(data_i.verts, data_i.i2);
    y3 = get_y(data_i.verts, data_i.i3);
  end

  // classify, order flat pairs by x, take differences
  always_comb begin
    prep_d.i1   = data_i.i1;
    prep_d.i2   = data_i.i2;
    prep_d.i3   = data_i.i3;
    prep_d.y1   = y1;
    prep_d.y2   = y2;
    prep_d.y3   = y3;
    prep_d.dx21 = diff_t'(x2) - diff_t'(x1);
    prep_d.dy31 = diff_t'(y3) - diff_t'(y1);
    prep_d.dx31 = diff_t'(x3) - diff_t'(x1);
    prep_d.dy21 = diff_t'(y2) - diff_t'(y1);
    if (((y1 == y2) && (y1 == y3)) || ((x1 == x2) && (x1 == x3))) begin
      prep_d.kind = KIND_REJECT;
    end else if (y1 == y2) begin
      prep_d.kind = KIND_FLAT_TOP;
      if (x1 > x2) begin
        prep_d.i1 = data_i.i2;
        prep_d.i2 = data_i.i1;
      end
    end else if (y2 == y3) begin
      prep_d.kind = KIND_FLAT_BOT;
      if (x2 > x3) begin
        prep_d.i2 = data_i.i3;
        prep_d.i3 = data_i.i2;
      end
    end else begin
      prep_d.kind = KIND_SPLIT;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= prep_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/tts_side.sv =====
// ----------------------------------------------------------------------------
// tts_side
// Stage 3: the two cross products for the middle vertex side test.
// ----------------------------------------------------------------------------
module tts_side import tts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  prep_t data_i,
  output logic  ready_o,
  output logic  valid_o,
  output side_t data_o,
  input  logic  ready_i
);

  side_t side_d;
  logic  valid_q;
  side_t data_q;

  // 17x17 signed products, pass the rest along
  always_comb begin
    side_d.kind = data_i.kind;
    side_d.i1   = data_i.i1;
    side_d.i2   = data_i.i2;
    side_d.i3   = data_i.i3;
    side_d.y1   = data_i.y1;
    side_d.y2   = data_i.y2;
    side_d.y3   = data_i.y3;
    side_d.lhs  = prod_t'(data_i.dx21) * prod_t'(data_i.dy31);
    side_d.rhs  = prod_t'(data_i.dx31) * prod_t'(data_i.dy21);
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/tts_emit.sv =====
// ----------------------------------------------------------------------------
// tts_emit
// Stage 4: side test, builds trapezoids, sends one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tts_emit import tts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  side_t    data_i,
  output logic     ready_o,
  output logic     out_valid_o,
  output tts_out_t out_data_o,
  input  logic     out_stall_i
);

  tts_out_t res0_d, res1_d;
  logic     two_d;
  logic     mid_left;
  tts_out_t res0_q, res1_q;
  logic     two_q;
  logic     valid_q;
  logic     phase_q, phase_d;
  logic     out_take;
  logic     done;

  // build the results of the incoming triangle
  always_comb begin
    mid_left = ($signed(data_i.lhs) <= $signed(data_i.rhs));
    res0_d   = '0;
    res1_d   = '0;
    two_d    = 1'b0;
    case (data_i.kind)
      KIND_REJECT: begin
        res0_d.last = 1'b1;
      end
      KIND_FLAT_TOP: begin
        res0_d = '{trap_valid: 1'b1, top_y: data_i.y1, bottom_y: data_i.y3,
                   left_start: data_i.i1, left_end: data_i.i3,
                   right_start: data_i.i2, right_end: data_i.i3, last: 1'b1};
      end
      KIND_FLAT_BOT: begin
        res0_d = '{trap_valid: 1'b1, top_y: data_i.y1, bottom_y: data_i.y3,
                   left_start: data_i.i1, left_end: data_i.i2,
                   right_start: data_i.i1, right_end: data_i.i3, last: 1'b1};
      end
      KIND_SPLIT: begin
        two_d = 1'b1;
        if (mid_left) begin
          res0_d = '{trap_valid: 1'b1, top_y: data_i.y1, bottom_y: data_i.y2,
                     left_start: data_i.i1, left_end: data_i.i2,
                     right_start: data_i.i1, right_end: data_i.i3, last: 1'b0};
          res1_d = '{trap_valid: 1'b1, top_y: data_i.y2, bottom_y: data_i.y3,
                     left_start: data_i.i2, left_end: data_i.i3,
                     right_start: data_i.i1, right_end: data_i.i3, last: 1'b1};
        end else begin
          res0_d = '{trap_valid: 1'b1, top_y: data_i.y1, bottom_y: data_i.y2,
                     left_start: data_i.i1, left_end: data_i.i3,
                     right_start: data_i.i1, right_end: data_i.i2, last: 1'b0};
          res1_d = '{trap_valid: 1'b1, top_y: data_i.y2, bottom_y: data_i.y3,
                     left_start: data_i.i1, left_end: data_i.i3,
                     right_start: data_i.i2, right_end: data_i.i3, last: 1'b1};
        end
      end
      default: begin
        res0_d.last = 1'b1;
      end
    endcase
  end

  // output handshake and phase of a split triangle
  assign out_take = out_valid_o && !out_stall_i;
  assign done     = out_take && (!two_q || phase_q);
  assign ready_o  = !valid_q || done;

  always_comb begin
    phase_d = phase_q;
    if (done) begin
      phase_d = 1'b0;
    end else if (out_take) begin
      phase_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (ready_o) begin
        valid_q <= valid_i;
      end
    end
  end

  // held results
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res0_q <= res0_d;
      res1_q <= res1_d;
      two_q  <= two_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = phase_q ? res1_q : res0_q;

  // second phase only exists for a held split triangle
  `ASSERT_RST(a_phase_split, clk_i, rst_ni,
    phase_q |-> (valid_q && two_q),
    "second result phase without a split triangle")
  // a first half that leaves is followed at once by the closing half
  `ASSERT_RST(a_split_follow, clk_i, rst_ni,
    (out_take && !out_data_o.last) |=> (out_valid_o && out_data_o.last),
    "split triangle lost its second trapezoid")
  // a rejected triangle closes with a single result
  `ASSERT_RST(a_reject_last, clk_i, rst_ni,
    (out_valid_o && !out_data_o.trap_valid) |-> out_data_o.last,
    "rejected triangle result not marked last")
  // trapezoids never run upward
  `ASSERT_RST(a_top_above, clk_i, rst_ni,
    (out_valid_o && out_data_o.trap_valid) |->
      ($signed(out_data_o.top_y) <= $signed(out_data_o.bottom_y)),
    "trapezoid top below its bottom")
  // nothing is shown while reset holds
  `ASSERT_ALWAYS(a_reset_idle, clk_i,
    !rst_ni |-> !out_valid_o,
    "result valid during reset")

endmodule

// ===== hdl/triangle_trapezoid_split.sv =====
// ----------------------------------------------------------------------------
// triangle_trapezoid_split
// Rasterizer setup: splits a screen-space triangle into trapezoids.
// ----------------------------------------------------------------------------
// A triangle item enters through in_data_i and passes four register stages:
// y sort, classification with edge differences, cross products, and the
// result register. Flat-top, flat-bottom and rejected triangles give one
// result item; any other triangle gives two result items and holds the
// result register until both have left, so a steady stream of triangles
// that are not split runs at one per cycle while the output does not stall.
// A new triangle is taken while earlier ones are still in flight; a stall
// on the output backs up through the stages without losing or repeating
// anything.
// ----------------------------------------------------------------------------
module triangle_trapezoid_split import tts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tts_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tts_out_t out_data_o
);

  logic  sort_ready, sort_valid;
  sort_t sort_data;
  logic  prep_ready, prep_valid;
  prep_t prep_data;
  logic  side_ready, side_valid;
  side_t side_data;
  logic  emit_ready;

  assign in_stall_o = !sort_ready;

  // stage 1: y sort
  tts_sort u_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .ready_o (sort_ready),
    .valid_o (sort_valid),
    .data_o  (sort_data),
    .ready_i (prep_ready)
  );

  // stage 2: classify and differences
  tts_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sort_valid),
    .data_i  (sort_data),
    .ready_o (prep_ready),
    .valid_o (prep_valid),
    .data_o  (prep_data),
    .ready_i (side_ready)
  );

  // stage 3: cross products
  tts_side u_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .data_i  (prep_data),
    .ready_o (side_ready),
    .valid_o (side_valid),
    .data_o  (side_data),
    .ready_i (emit_ready)
  );

  // stage 4: side decision and result output
  tts_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (side_valid),
    .data_i      (side_data),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle to trapezoid split.
// ----------------------------------------------------------------------------
// Triangles go in through the valid/stall input channel and trapezoid items
// come back on the output channel. A scoreboard works out the trapezoids of
// every accepted triangle: y sort, rejection, flat top, flat bottom, or a
// split at the middle vertex. It then checks each result item, field by
// field, in order. Directed corner triangles run first, then random
// triangles under three idling mixes on both channels.
// ----------------------------------------------------------------------------
module testbench import tts_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // expected trapezoids per accepted triangle, checked in arrival order
  class trap_scoreboard;
    tts_out_t traps_due[$];
    int       mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function int outstanding();
      return traps_due.size();
    endfunction

    function tts_out_t make_trap(logic ok, coord_t top, coord_t bot, vidx_t ls,
                                 vidx_t le, vidx_t rs, vidx_t re, logic fin);
      tts_out_t r;
      r.trap_valid  = ok;
      r.top_y       = top;
      r.bottom_y    = bot;
      r.left_start  = ls;
      r.left_end    = le;
      r.right_start = rs;
      r.right_end   = re;
      r.last        = fin;
      return r;
    endfunction

    // work out the trapezoids of one accepted triangle
    function void note_triangle(tts_in_t tri_in);
      coord_t   vx[3];
      coord_t   vy[3];
      vidx_t    i1, i2, i3, tmp;
      diff_t    dx21, dy31, dx31, dy21;
      prod_t    lhs, rhs;
      tts_out_t none;
      vx[VIDX_A] = tri_in.ax;
      vy[VIDX_A] = tri_in.ay;
      vx[VIDX_B] = tri_in.bx;
      vy[VIDX_B] = tri_in.by_coord;
      vx[VIDX_C] = tri_in.cx;
      vy[VIDX_C] = tri_in.cy;
      i1 = VIDX_A;
      i2 = VIDX_B;
      i3 = VIDX_C;
      // strict compare-swaps, which need not keep input order on equal y
      if (vy[i1] > vy[i2]) begin
        tmp = i1; i1 = i2; i2 = tmp;
      end
      if (vy[i1] > vy[i3]) begin
        tmp = i1; i1 = i3; i3 = tmp;
      end
      if (vy[i2] > vy[i3]) begin
        tmp = i2; i2 = i3; i3 = tmp;
      end
      // one y or one x for all three: rejected
      if ((vy[i1] == vy[i2] && vy[i1] == vy[i3]) ||
          (vx[i1] == vx[i2] && vx[i1] == vx[i3])) begin
        none = '0;
        none.last = 1'b1;
        traps_due.push_back(none);
        return;
      end
      // flat top: upper pair ordered by x
      if (vy[i1] == vy[i2]) begin
        if (vx[i1] > vx[i2]) begin
          tmp = i1; i1 = i2; i2 = tmp;
        end
        traps_due.push_back(make_trap(1'b1, vy[i1], vy[i3], i1, i3, i2, i3, 1'b1));
        return;
      end
      // flat bottom: lower pair ordered by x
      if (vy[i2] == vy[i3]) begin
        if (vx[i2] > vx[i3]) begin
          tmp = i2; i2 = i3; i3 = tmp;
        end
        traps_due.push_back(make_trap(1'b1, vy[i1], vy[i3], i1, i2, i1, i3, 1'b1));
        return;
      end
      // side of the middle vertex by exact cross products, zero counts as left
      dx21 = diff_t'(vx[i2]) - diff_t'(vx[i1]);
      dy31 = diff_t'(vy[i3]) - diff_t'(vy[i1]);
      dx31 = diff_t'(vx[i3]) - diff_t'(vx[i1]);
      dy21 = diff_t'(vy[i2]) - diff_t'(vy[i1]);
      lhs  = prod_t'(dx21) * prod_t'(dy31);
      rhs  = prod_t'(dx31) * prod_t'(dy21);
      if (lhs <= rhs) begin
        traps_due.push_back(make_trap(1'b1, vy[i1], vy[i2], i1, i2, i1, i3, 1'b0));
        traps_due.push_back(make_trap(1'b1, vy[i2], vy[i3], i2, i3, i1, i3, 1'b1));
      end else begin
        traps_due.push_back(make_trap(1'b1, vy[i1], vy[i2], i1, i3, i1, i2, 1'b0));
        traps_due.push_back(make_trap(1'b1, vy[i2], vy[i3], i1, i3, i2, i3, 1'b1));
      end
    endfunction

    function void compare_field(string field, diff_t want, diff_t got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatch_count++;
      end
    endfunction

    // check one accepted trapezoid item against the oldest expectation
    function void check_trap(tts_out_t got);
      tts_out_t want;
      if (traps_due.size() == 0) begin
        $error("trapezoid item with no triangle waiting for it");
        mismatch_count++;
        return;
      end
      want = traps_due.pop_front();
      compare_field("trap_valid", diff_t'(want.trap_valid), diff_t'(got.trap_valid));
      compare_field("top_y", diff_t'(want.top_y), diff_t'(got.top_y));
      compare_field("bottom_y", diff_t'(want.bottom_y), diff_t'(got.bottom_y));
      compare_field("left_start", diff_t'(want.left_start), diff_t'(got.left_start));
      compare_field("left_end", diff_t'(want.left_end), diff_t'(got.left_end));
      compare_field("right_start", diff_t'(want.right_start), diff_t'(got.right_start));
      compare_field("right_end", diff_t'(want.right_end), diff_t'(got.right_end));
      compare_field("last", diff_t'(want.last), diff_t'(got.last));
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tts_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tts_out_t out_data_o;

  int send_idle_pct;
  int recv_idle_pct;

  trap_scoreboard sb;

  triangle_trapezoid_split dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: check accepted items, then pick next cycle's stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_trap(out_data_o);
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // offer one triangle, called at a clock edge, returns at its accepting edge
  task automatic send_triangle(input tts_in_t tri_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tri_in;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_triangle(tri_in);
  endtask

  task automatic send_xy(input int ax, input int ay, input int bx, input int by,
                         input int cx, input int cy);
    tts_in_t t;
    t.ax       = coord_t'(ax);
    t.ay       = coord_t'(ay);
    t.bx       = coord_t'(bx);
    t.by_coord = coord_t'(by);
    t.cx       = coord_t'(cx);
    t.cy       = coord_t'(cy);
    send_triangle(t);
  endtask

  // hold the input until every expected trapezoid has come back
  task automatic drain_traps();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(4))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  // random triangle: often full range, with coincident, flat, degenerate,
  // collinear and extreme shapes mixed in
  function automatic tts_in_t random_triangle();
    coord_t  vx[3];
    coord_t  vy[3];
    tts_in_t t;
    int      shape, j, k, x0, y0, dx, dy, m;
    shape = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      if (shape == 4 || shape == 5 || (shape >= 6 && shape <= 7 && i[0])) begin
        vx[i] = coord_t'(int'($urandom_range(8)) - 4);
        vy[i] = coord_t'(int'($urandom_range(8)) - 4);
      end else if (shape == 9) begin
        vx[i] = pick_extreme();
        vy[i] = pick_extreme();
      end else begin
        vx[i] = coord_t'($urandom);
        vy[i] = coord_t'($urandom);
      end
    end
    j = $urandom_range(2);
    k = (j + 1 + $urandom_range(1)) % 3;
    case (shape)
      // flat top or bottom
      6: vy[k] = vy[j];
      // one x or one y for all
      7: begin
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(1) == 0) vx[i] = vx[j];
          else vy[i] = vy[j];
        end
        if ($urandom_range(1) == 0) begin
          vx[0] = vx[j]; vx[1] = vx[j]; vx[2] = vx[j];
        end else begin
          vy[0] = vy[j]; vy[1] = vy[j]; vy[2] = vy[j];
        end
      end
      // collinear along a random direction
      8: begin
        x0 = int'($urandom_range(2000)) - 1000;
        y0 = int'($urandom_range(2000)) - 1000;
        dx = int'($urandom_range(100)) - 50;
        dy = int'($urandom_range(100)) - 50;
        for (int i = 0; i < 3; i++) begin
          m = int'($urandom_range(20)) - 10;
          vx[i] = coord_t'(x0 + m * dx);
          vy[i] = coord_t'(y0 + m * dy);
        end
      end
      default: ;
    endcase
    t.ax       = vx[0];
    t.ay       = vy[0];
    t.bx       = vx[1];
    t.by_coord = vy[1];
    t.cx       = vx[2];
    t.cy       = vy[2];
    return t;
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_triangle(random_triangle());
    end
  endtask

  // stimulus
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    send_idle_pct = 32;
    recv_idle_pct = 84;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rejected: one y, one x, one point, extreme y
    send_xy(0, 5, 10, 5, -7, 5);
    send_xy(3, 0, 3, -9, 3, 40);
    send_xy(1, 1, 1, 1, 1, 1);
    send_xy(-32768, 32767, 32767, 32767, 0, 32767);
    send_xy(32767, -32768, 32767, 32767, 32767, 0);
    // flat top: swapped, equal x kept, upper pair is b and c
    send_xy(20, 0, -20, 0, 0, 30);
    send_xy(5, 0, 5, 0, 9, 16);
    send_xy(0, 50, 10, -3, -10, -3);
    // flat bottom: swapped, in order, equal x kept, pair a and c, pair a and b
    send_xy(0, 0, 30, 40, -30, 40);
    send_xy(-30, 40, 0, -8, 30, 40);
    send_xy(2, 0, 7, 9, 7, 9);
    send_xy(0, 10, 5, 0, -5, 10);
    send_xy(0, 7, 9, 7, 4, -2);
    // split: middle left, middle right, reversed y order
    send_xy(0, 0, -50, 20, 10, 60);
    send_xy(0, 0, 50, 20, -10, 60);
    send_xy(1, 30, 2, 20, 3, 10);
    // collinear but not degenerate
    send_xy(0, 0, 10, 10, 20, 20);
    send_xy(20, 20, 0, 0, 10, 10);
    // extremes of every field
    send_xy(-32768, -32768, 32767, 0, -32768, 32767);
    send_xy(32767, -32768, -32768, 0, 32767, 32767);
    send_xy(-32768, 32767, 32767, -32768, 0, 0);
    send_xy(-1, -1, 0, 0, 1, -1);
    send_xy(-1, 0, 0, -1, -1, -1);
    drain_traps();

    send_random(260);
    drain_traps();
    send_idle_pct = 84;
    recv_idle_pct = 32;
    send_random(260);
    drain_traps();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(260);
    drain_traps();

    if (sb.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tts_pkg.sv
hdl/tts_sort.sv
hdl/tts_prep.sv
hdl/tts_side.sv
hdl/tts_emit.sv
hdl/triangle_trapezoid_split.sv
sim/testbench.sv
